### rtl/mbp_pkg.sv
`timescale 1ns / 1ps

package mbp_pkg;

   localparam int SYSEX_DEPTH_DEF  = 63;
   localparam int CMD_QUEUE_DEPTH  = 2;
   localparam int CMD_LEN_W        = 6;

   localparam logic [7:0] ST_SOX  = 8'hF0;
   localparam logic [7:0] ST_EOX  = 8'hF7;
   localparam logic [7:0] RT_MIN  = 8'hF8;

   localparam logic [1:0] KIND_REALTIME = 2'd0;
   localparam logic [1:0] KIND_CHANNEL  = 2'd1;
   localparam logic [1:0] KIND_COMMON   = 2'd2;
   localparam logic [1:0] KIND_SYSEX    = 2'd3;

   typedef enum logic [1:0] {
      OP_SINGLE,
      OP_MSG,
      OP_DUMP
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type             op;
      logic [7:0]             byte0;
      logic [6:0]             d0;
      logic [6:0]             d1;
      logic                   two;
      logic [1:0]             kind;
      logic [CMD_LEN_W-1:0]   len;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MSG,
      BK_DUMP_RD,
      BK_DUMP_OUT,
      BK_TAIL
   } bk_state_type;

   // data bytes that follow a status byte
   function automatic logic [1:0] data_count(input logic [7:0] status);
      logic [1:0] n;
      n = 2'd0;
      unique case (status[7:4])
         4'hC, 4'hD:                   n = 2'd1;
         4'h8, 4'h9, 4'hA, 4'hB, 4'hE: n = 2'd2;
         4'hF: begin
            if (status == 8'hF1 || status == 8'hF3) n = 2'd1;
            else if (status == 8'hF2)               n = 2'd2;
            else                                    n = 2'd0;
         end
         default:                      n = 2'd0;
      endcase
      return n;
   endfunction

endpackage

### rtl/mbp_if.sv
`timescale 1ns / 1ps

interface mbp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface mbp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] msg_byte;
   logic       last;
   logic [1:0] msg_kind;

   modport source (output valid, output msg_byte, output last, output msg_kind, input ready);
   modport sink   (input valid, input msg_byte, input last, input msg_kind, output ready);
endinterface

### rtl/midi_byte_stream_message_parser.sv
`timescale 1ns / 1ps
// channel  dir  payload                         role
// req_ch   in   data_byte[7:0]                  raw byte stream
// rsp_ch   out  msg_byte[7:0], last, msg_kind   assembled messages, one byte per item
//
// one input byte is taken per cycle while the queue has room and no sysex is read out
// a channel or common message leaves one byte per cycle while the output is taken
// a sysex first fetches its command, then each buffered byte is read from the
// registered buffer before it leaves, and f7 follows the last one
// input is held off until f7 has been loaded into the output register
// synchronous reset; the sysex buffer needs no clearing, so items are taken at once

module midi_byte_stream_message_parser #(
   parameter int SYSEX_DEPTH = mbp_pkg::SYSEX_DEPTH_DEF,
   parameter int QUEUE_DEPTH = mbp_pkg::CMD_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   mbp_req_if.sink          req_ch,
   mbp_rsp_if.source        rsp_ch
);
   import mbp_pkg::*;

   localparam int ADDR_W = $clog2(SYSEX_DEPTH);

   logic              push, pop, q_full, q_empty, dump_done;
   cmd_type           push_cmd, head;
   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [7:0]        ram_wr_data, ram_rd_data;

   mbp_front #(.SYSEX_DEPTH(SYSEX_DEPTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .data_byte   (req_ch.data_byte),
      .push        (push),
      .push_cmd    (push_cmd),
      .q_full      (q_full),
      .dump_done   (dump_done),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   mbp_cmd_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .empty    (q_empty),
      .head     (head)
   );

   mbp_ram #(.WIDTH(8), .DEPTH(SYSEX_DEPTH)) u_sysex_buf (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mbp_back #(.SYSEX_DEPTH(SYSEX_DEPTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .head        (head),
      .pop         (pop),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .dump_done   (dump_done),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .msg_byte    (rsp_ch.msg_byte),
      .last        (rsp_ch.last),
      .msg_kind    (rsp_ch.msg_kind)
   );
endmodule

### rtl/mbp_ram.sv
`timescale 1ns / 1ps

module mbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 63
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/mbp_cmd_fifo.sv
`timescale 1ns / 1ps

module mbp_cmd_fifo #(
   parameter int DEPTH = mbp_pkg::CMD_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mbp_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output mbp_pkg::cmd_type head
);
   import mbp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule

### rtl/mbp_front.sv
`timescale 1ns / 1ps

module mbp_front #(
   parameter int SYSEX_DEPTH = mbp_pkg::SYSEX_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     data_byte,
   output logic                           push,
   output mbp_pkg::cmd_type               push_cmd,
   input  logic                           q_full,
   input  logic                           dump_done,
   output logic                           ram_wr_en,
   output logic [$clog2(SYSEX_DEPTH)-1:0] ram_wr_addr,
   output logic [7:0]                     ram_wr_data
);
   import mbp_pkg::*;

   localparam int ADDR_W = $clog2(SYSEX_DEPTH);
   localparam int LEN_W  = $clog2(SYSEX_DEPTH + 1);

   logic             in_sysex_ff, in_sysex_in;
   logic [7:0]       rs_ff, rs_in;
   logic [1:0]       need_ff, need_in;
   logic [1:0]       got_ff, got_in;
   logic [6:0]       hold0_ff, hold0_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             dump_pend_ff, dump_pend_in;
   logic             accept;
   logic [1:0]       need_new;
   logic [1:0]       got_next;

   // no new item while the queue is full or the buffer is being read out
   assign req_ready = !q_full && !dump_pend_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      in_sysex_in  = in_sysex_ff;
      rs_in        = rs_ff;
      need_in      = need_ff;
      got_in       = got_ff;
      hold0_in     = hold0_ff;
      len_in       = len_ff;
      dump_pend_in = dump_pend_ff;
      push         = 1'b0;
      push_cmd     = '0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = len_ff[ADDR_W-1:0];
      ram_wr_data  = data_byte;
      need_new     = data_count(data_byte);
      got_next     = got_ff + 2'd1;

      if (dump_done) begin
         dump_pend_in = 1'b0;
      end

      if (accept) begin
         priority if (data_byte >= RT_MIN) begin
            push           = 1'b1;
            push_cmd.op    = OP_SINGLE;
            push_cmd.byte0 = data_byte;
            push_cmd.kind  = KIND_REALTIME;
         end else if (in_sysex_ff && data_byte == ST_EOX) begin
            push           = 1'b1;
            push_cmd.op    = OP_DUMP;
            push_cmd.kind  = KIND_SYSEX;
            push_cmd.len   = CMD_LEN_W'(len_ff);
            in_sysex_in    = 1'b0;
            len_in         = '0;
            dump_pend_in   = 1'b1;
         end else if (in_sysex_ff && !data_byte[7]) begin
            // bytes past the buffer are dropped
            if (len_ff < LEN_W'(SYSEX_DEPTH)) begin
               ram_wr_en = 1'b1;
               len_in    = len_ff + LEN_W'(1);
            end
         end else if (data_byte[7]) begin
            // status byte, possibly cutting off an open sysex
            in_sysex_in = 1'b0;
            len_in      = '0;
            if (data_byte == ST_SOX) begin
               in_sysex_in = 1'b1;
               ram_wr_en   = 1'b1;
               ram_wr_addr = '0;
               len_in      = LEN_W'(1);
               rs_in       = '0;
            end else begin
               rs_in   = data_byte;
               need_in = need_new;
               got_in  = 2'd0;
               if (need_new == 2'd0) begin
                  rs_in          = '0;
                  push           = 1'b1;
                  push_cmd.op    = OP_SINGLE;
                  push_cmd.byte0 = data_byte;
                  push_cmd.kind  = (data_byte < ST_SOX) ? KIND_CHANNEL : KIND_COMMON;
               end
            end
         end else if (rs_ff != '0 && need_ff != 2'd0) begin
            if (got_ff == 2'd0) begin
               hold0_in = data_byte[6:0];
            end
            if (got_next >= need_ff) begin
               push           = 1'b1;
               push_cmd.op    = OP_MSG;
               push_cmd.byte0 = rs_ff;
               push_cmd.d0    = (need_ff == 2'd1) ? data_byte[6:0] : hold0_ff;
               push_cmd.d1    = data_byte[6:0];
               push_cmd.two   = (need_ff == 2'd2);
               push_cmd.kind  = (rs_ff < ST_SOX) ? KIND_CHANNEL : KIND_COMMON;
               got_in         = 2'd0;
               if (rs_ff >= ST_SOX) begin
                  rs_in = '0;
               end
            end else begin
               got_in = got_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sysex_ff  <= 1'b0;
         rs_ff        <= '0;
         need_ff      <= '0;
         got_ff       <= '0;
         len_ff       <= '0;
         dump_pend_ff <= 1'b0;
      end else begin
         in_sysex_ff  <= in_sysex_in;
         rs_ff        <= rs_in;
         need_ff      <= need_in;
         got_ff       <= got_in;
         len_ff       <= len_in;
         dump_pend_ff <= dump_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      hold0_ff <= hold0_in;
   end
endmodule

### rtl/mbp_back.sv
`timescale 1ns / 1ps

module mbp_back #(
   parameter int SYSEX_DEPTH = mbp_pkg::SYSEX_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  mbp_pkg::cmd_type               head,
   output logic                           pop,
   output logic                           ram_rd_en,
   output logic [$clog2(SYSEX_DEPTH)-1:0] ram_rd_addr,
   input  logic [7:0]                     ram_rd_data,
   output logic                           dump_done,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     msg_byte,
   output logic                           last,
   output logic [1:0]                     msg_kind
);
   import mbp_pkg::*;

   localparam int ADDR_W = $clog2(SYSEX_DEPTH);
   localparam int LEN_W  = $clog2(SYSEX_DEPTH + 1);

   bk_state_type     state_ff, state_in;
   cmd_type          cur_ff, cur_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic [1:0]       kind_ff, kind_in;
   logic             out_free;
   logic             load_out;
   logic [LEN_W-1:0] cur_len;
   logic             buf_end;

   // output register frees when empty or being taken
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cur_len  = LEN_W'(cur_ff.len);
   assign buf_end  = ((idx_ff + LEN_W'(1)) == cur_len);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty && out_free) begin
               unique case (head.op)
                  OP_MSG:  state_in = BK_MSG;
                  OP_DUMP: state_in = BK_DUMP_RD;
                  default: state_in = BK_IDLE;
               endcase
            end
         end
         BK_MSG: begin
            if (out_free) begin
               state_in = (idx_ff == LEN_W'(1) && cur_ff.two) ? BK_MSG : BK_IDLE;
            end
         end
         BK_DUMP_RD: state_in = BK_DUMP_OUT;
         BK_DUMP_OUT: begin
            if (out_free) begin
               state_in = buf_end ? BK_TAIL : BK_DUMP_RD;
            end
         end
         BK_TAIL: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      cur_in      = cur_ff;
      idx_in      = idx_ff;
      pop         = 1'b0;
      load_out    = 1'b0;
      byte_in     = byte_ff;
      last_in     = last_ff;
      kind_in     = kind_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff[ADDR_W-1:0];
      dump_done   = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty && out_free) begin
               pop    = 1'b1;
               cur_in = head;
               idx_in = LEN_W'(1);
               unique case (head.op)
                  OP_SINGLE: begin
                     load_out = 1'b1;
                     byte_in  = head.byte0;
                     last_in  = 1'b1;
                     kind_in  = head.kind;
                  end
                  OP_MSG: begin
                     load_out = 1'b1;
                     byte_in  = head.byte0;
                     last_in  = 1'b0;
                     kind_in  = head.kind;
                  end
                  OP_DUMP: begin
                     idx_in = '0;
                  end
                  default: begin
                     pop = 1'b0;
                  end
               endcase
            end
         end
         BK_MSG: begin
            if (out_free) begin
               load_out = 1'b1;
               kind_in  = cur_ff.kind;
               if (idx_ff == LEN_W'(1)) begin
                  byte_in = {1'b0, cur_ff.d0};
                  last_in = !cur_ff.two;
                  idx_in  = LEN_W'(2);
               end else begin
                  byte_in = {1'b0, cur_ff.d1};
                  last_in = 1'b1;
               end
            end
         end
         BK_DUMP_RD: begin
            ram_rd_en = 1'b1;
         end
         BK_DUMP_OUT: begin
            if (out_free) begin
               load_out = 1'b1;
               byte_in  = ram_rd_data;
               last_in  = 1'b0;
               kind_in  = KIND_SYSEX;
               idx_in   = idx_ff + LEN_W'(1);
            end
         end
         BK_TAIL: begin
            if (out_free) begin
               load_out  = 1'b1;
               byte_in   = ST_EOX;
               last_in   = 1'b1;
               kind_in   = KIND_SYSEX;
               dump_done = 1'b1;
            end
         end
         default: begin
            load_out = 1'b0;
         end
      endcase

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      kind_ff <= kind_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign msg_byte  = byte_ff;
   assign last      = last_ff;
   assign msg_kind  = kind_ff;
endmodule

### rtl/mbp_checker.sv
`timescale 1ns / 1ps

module mbp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] msg_byte,
   input logic       last,
   input logic [1:0] msg_kind
);
   import mbp_pkg::*;

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(msg_byte) && $stable(last)
         && $stable(msg_kind))
      else $error("rsp item changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // real-time bytes travel alone
   a_realtime: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && msg_kind == KIND_REALTIME |-> last && msg_byte >= RT_MIN)
      else $error("bad real-time item");

   a_sysex_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && msg_kind == KIND_SYSEX && last |-> msg_byte == ST_EOX)
      else $error("sysex not closed by f7");

   a_channel_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && msg_kind == KIND_CHANNEL |-> msg_byte < ST_SOX)
      else $error("system byte tagged as channel voice");
endmodule

bind midi_byte_stream_message_parser mbp_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .msg_byte  (rsp_ch.msg_byte),
   .last      (rsp_ch.last),
   .msg_kind  (rsp_ch.msg_kind)
);
